[sv/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SRHT_ASSERT_IMP(name, clk_s, rstn_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define SRHT_ASSERT_NXT(name, clk_s, rstn_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/srht_pkg.sv]
package srht_pkg;

	// Edge order of the hit mask; edge k runs from corner k to corner k+1.
	localparam int NUM_EDGES   = 4;
	localparam int EDGE_TOP    = 0;
	localparam int EDGE_RIGHT  = 1;
	localparam int EDGE_BOTTOM = 2;
	localparam int EDGE_LEFT   = 3;

	// Per-stage flow control: valid from the stage before, advance of this stage.
	typedef struct packed {
		logic valid;
		logic adv;
	} pipe_ctl_t;

	// Sign of a cross product.
	typedef struct packed {
		logic neg;
		logic zero;
	} sign_t;

endpackage

[sv/segment_rectangle_hit_test_core.sv]
// An input transfer reaches its result on the output port through the register stages s1 to s4.
// Throughput: one query per cycle unless the output stalls; each of the four register stages holds one item.
// A stalled output holds the pipe back stage by stage; bubbles are squeezed out.
// Reset (arst_n low, asynchronous) clears every stage valid bit; data registers keep
// whatever they hold and are ignored until a new item arrives.
`include "assert_macros.svh"

module segment_rectangle_hit_test_core import srht_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_x,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_y,
	input  logic signed [COORD_WIDTH-1:0] ray_vector_x,
	input  logic signed [COORD_WIDTH-1:0] ray_vector_y,
	input  logic signed [COORD_WIDTH-1:0] rect_corner_x,
	input  logic signed [COORD_WIDTH-1:0] rect_corner_y,
	input  logic        [COORD_WIDTH-2:0] rect_width,
	input  logic        [COORD_WIDTH-2:0] rect_height,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic        [NUM_EDGES-1:0]   edge_hits
);

	// Pipeline overview
	//   s1: corner offsets from the ray origin (dx0, dx1, dy0, dy1), edge degeneracy flags.
	//   s2: four products Vx*dy and Vy*dx; side test of both ray ends against each edge
	//       line. Edges are axis aligned, so that cross product reduces to a sign compare.
	//   s3: ray-line cross product for each of the four corners, kept as sign only.
	//   s4: per-edge reject from the corner signs, OR'ed into hit; this is the output
	//       register.
	// Coordinates widen to COORD_WIDTH+2 bits for offsets and 2*COORD_WIDTH+3 for the
	// cross difference, so no sum or product wraps.

	localparam int CW = COORD_WIDTH;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 adv_s1, adv_s2, adv_s3, adv_s4;
	logic signed [CW+1:0] dx0_s1, dx1_s1, dy0_s1, dy1_s1;
	logic signed [CW-1:0] vx_s1, vy_s1;
	logic                 w_nz_s1, h_nz_s1;
	sign_t [NUM_EDGES-1:0] sgn_s3;
	logic  [NUM_EDGES-1:0] erej_s3;
	pipe_ctl_t            ctl_s1, ctl_s2, ctl_s4;

	// Advance a stage when it is empty or its successor advances too.
	assign adv_s4   = !out_valid || !out_stall;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	assign ctl_s1 = '{valid: in_valid, adv: adv_s1};
	assign ctl_s2 = '{valid: valid_s1, adv: adv_s2};
	assign ctl_s4 = '{valid: valid_s3, adv: adv_s4};

	srht_prep #(.CW(CW)) u_prep (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl_s1),
		.ray_origin_x  (ray_origin_x),
		.ray_origin_y  (ray_origin_y),
		.ray_vector_x  (ray_vector_x),
		.ray_vector_y  (ray_vector_y),
		.rect_corner_x (rect_corner_x),
		.rect_corner_y (rect_corner_y),
		.rect_width    (rect_width),
		.rect_height   (rect_height),
		.valid_s1      (valid_s1),
		.dx0_s1        (dx0_s1),
		.dx1_s1        (dx1_s1),
		.dy0_s1        (dy0_s1),
		.dy1_s1        (dy1_s1),
		.vx_s1         (vx_s1),
		.vy_s1         (vy_s1),
		.w_nz_s1       (w_nz_s1),
		.h_nz_s1       (h_nz_s1)
	);

	srht_cross #(.CW(CW)) u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s2   (ctl_s2),
		.adv_s3   (adv_s3),
		.dx0_s1   (dx0_s1),
		.dx1_s1   (dx1_s1),
		.dy0_s1   (dy0_s1),
		.dy1_s1   (dy1_s1),
		.vx_s1    (vx_s1),
		.vy_s1    (vy_s1),
		.w_nz_s1  (w_nz_s1),
		.h_nz_s1  (h_nz_s1),
		.valid_s2 (valid_s2),
		.valid_s3 (valid_s3),
		.sgn_s3   (sgn_s3),
		.erej_s3  (erej_s3)
	);

	// The output register doubles as stage 4; it is the only place a result waits.
	srht_resolve u_resolve (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl_s4),
		.sgn_s3       (sgn_s3),
		.erej_s3      (erej_s3),
		.valid_s4     (out_valid),
		.hit_s4       (hit),
		.edge_hits_s4 (edge_hits)
	);

	// An accepted transfer always lands in stage 1.
	`SRHT_ASSERT_NXT(a_accept_enters, clk, arst_n, in_valid && !in_stall, valid_s1, "accepted item lost at stage 1")
	// Input stalls only when every stage is full and the output is blocked.
	`SRHT_ASSERT_IMP(a_stall_when_full, clk, arst_n, in_stall, valid_s1 && valid_s2 && valid_s3 && out_valid && out_stall, "input stalled with room in the pipe")
	// A taken result with nothing behind it leaves the output empty.
	`SRHT_ASSERT_NXT(a_no_repeat, clk, arst_n, out_valid && !out_stall && !valid_s3, !out_valid, "result repeated on output")
	// The summary bit agrees with the edge mask.
	`SRHT_ASSERT_IMP(a_hit_mask, clk, arst_n, out_valid, hit == (edge_hits != '0), "hit disagrees with edge mask")

endmodule

[sv/srht_prep.sv]
module srht_prep import srht_pkg::*; #(
	parameter int CW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pipe_ctl_t            ctl,
	input  logic signed [CW-1:0] ray_origin_x,
	input  logic signed [CW-1:0] ray_origin_y,
	input  logic signed [CW-1:0] ray_vector_x,
	input  logic signed [CW-1:0] ray_vector_y,
	input  logic signed [CW-1:0] rect_corner_x,
	input  logic signed [CW-1:0] rect_corner_y,
	input  logic        [CW-2:0] rect_width,
	input  logic        [CW-2:0] rect_height,
	output logic                 valid_s1,
	output logic signed [CW+1:0] dx0_s1,
	output logic signed [CW+1:0] dx1_s1,
	output logic signed [CW+1:0] dy0_s1,
	output logic signed [CW+1:0] dy1_s1,
	output logic signed [CW-1:0] vx_s1,
	output logic signed [CW-1:0] vy_s1,
	output logic                 w_nz_s1,
	output logic                 h_nz_s1
);

	localparam int DW = CW + 2;

	logic signed [DW-1:0] ox_e, oy_e, cx_e, cy_e, w_e, h_e;
	logic signed [DW-1:0] dx0, dx1, dy0, dy1;

	assign ox_e = DW'(ray_origin_x);
	assign oy_e = DW'(ray_origin_y);
	assign cx_e = DW'(rect_corner_x);
	assign cy_e = DW'(rect_corner_y);
	assign w_e  = DW'(rect_width);
	assign h_e  = DW'(rect_height);

	// Corner offsets from the ray origin.
	assign dx0 = cx_e - ox_e;
	assign dx1 = cx_e + w_e - ox_e;
	assign dy0 = cy_e - oy_e;
	assign dy1 = cy_e + h_e - oy_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.valid) begin
			dx0_s1  <= dx0;
			dx1_s1  <= dx1;
			dy0_s1  <= dy0;
			dy1_s1  <= dy1;
			vx_s1   <= ray_vector_x;
			vy_s1   <= ray_vector_y;
			w_nz_s1 <= (rect_width != '0);
			h_nz_s1 <= (rect_height != '0);
		end
	end

endmodule

[sv/srht_cross.sv]
module srht_cross import srht_pkg::*; #(
	parameter int CW = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pipe_ctl_t                   ctl_s2,
	input  logic                        adv_s3,
	input  logic signed [CW+1:0]        dx0_s1,
	input  logic signed [CW+1:0]        dx1_s1,
	input  logic signed [CW+1:0]        dy0_s1,
	input  logic signed [CW+1:0]        dy1_s1,
	input  logic signed [CW-1:0]        vx_s1,
	input  logic signed [CW-1:0]        vy_s1,
	input  logic                        w_nz_s1,
	input  logic                        h_nz_s1,
	output logic                        valid_s2,
	output logic                        valid_s3,
	output sign_t [NUM_EDGES-1:0]       sgn_s3,
	output logic  [NUM_EDGES-1:0]       erej_s3
);

	localparam int DW = CW + 2;
	localparam int PW = CW + DW;
	localparam int XW = PW + 1;

	// Both nonzero and on the same side.
	function automatic logic strict_same(input logic signed [DW:0] a, input logic signed [DW:0] b);
		strict_same = (a != '0) && (b != '0) && (a[DW] == b[DW]);
	endfunction

	logic signed [PW-1:0] pxy0, pxy1, pyx0, pyx1;
	logic signed [PW-1:0] pxy0_s2, pxy1_s2, pyx0_s2, pyx1_s2;
	logic [NUM_EDGES-1:0] erej, erej_s2;
	logic signed [XW-1:0] cr [NUM_EDGES];
	sign_t [NUM_EDGES-1:0] sgn;

	// Stage 2: the four products, and the edge-line side test for each edge.
	assign pxy0 = PW'(vx_s1) * PW'(dy0_s1);
	assign pxy1 = PW'(vx_s1) * PW'(dy1_s1);
	assign pyx0 = PW'(vy_s1) * PW'(dx0_s1);
	assign pyx1 = PW'(vy_s1) * PW'(dx1_s1);

	assign erej[EDGE_TOP]    = w_nz_s1 && strict_same((DW+1)'(dy0_s1),
	                                                   (DW+1)'(dy0_s1) - (DW+1)'(vy_s1));
	assign erej[EDGE_RIGHT]  = h_nz_s1 && strict_same((DW+1)'(dx1_s1),
	                                                   (DW+1)'(dx1_s1) - (DW+1)'(vx_s1));
	assign erej[EDGE_BOTTOM] = w_nz_s1 && strict_same((DW+1)'(dy1_s1),
	                                                   (DW+1)'(dy1_s1) - (DW+1)'(vy_s1));
	assign erej[EDGE_LEFT]   = h_nz_s1 && strict_same((DW+1)'(dx0_s1),
	                                                   (DW+1)'(dx0_s1) - (DW+1)'(vx_s1));

	// Stage 3: cross of the ray vector with each corner offset, reduced to its sign.
	assign cr[0] = XW'(pxy0_s2) - XW'(pyx0_s2);
	assign cr[1] = XW'(pxy0_s2) - XW'(pyx1_s2);
	assign cr[2] = XW'(pxy1_s2) - XW'(pyx1_s2);
	assign cr[3] = XW'(pxy1_s2) - XW'(pyx0_s2);

	for (genvar k = 0; k < NUM_EDGES; k++) begin : g_sign
		assign sgn[k].neg  = cr[k][XW-1];
		assign sgn[k].zero = (cr[k] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ctl_s2.adv) begin
				valid_s2 <= ctl_s2.valid;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.adv && ctl_s2.valid) begin
			pxy0_s2 <= pxy0;
			pxy1_s2 <= pxy1;
			pyx0_s2 <= pyx0;
			pyx1_s2 <= pyx1;
			erej_s2 <= erej;
		end
		if (adv_s3 && valid_s2) begin
			sgn_s3  <= sgn;
			erej_s3 <= erej_s2;
		end
	end

endmodule

[sv/srht_resolve.sv]
module srht_resolve import srht_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pipe_ctl_t             ctl,
	input  sign_t [NUM_EDGES-1:0] sgn_s3,
	input  logic  [NUM_EDGES-1:0] erej_s3,
	output logic                  valid_s4,
	output logic                  hit_s4,
	output logic  [NUM_EDGES-1:0] edge_hits_s4
);

	logic [NUM_EDGES-1:0] rrej, hits;

	// Reject an edge when both of its corners lie strictly on one side of the ray line.
	for (genvar k = 0; k < NUM_EDGES; k++) begin : g_edge
		localparam int NX = (k == NUM_EDGES - 1) ? 0 : k + 1;
		assign rrej[k] = !sgn_s3[k].zero && !sgn_s3[NX].zero
		                 && (sgn_s3[k].neg == sgn_s3[NX].neg);
	end

	assign hits = ~(rrej | erej_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s4 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.valid) begin
			edge_hits_s4 <= hits;
			hit_s4       <= |hits;
		end
	end

endmodule

[verif/segment_rectangle_hit_test_core_test.sv]
`timescale 1ns / 1ps

localparam int QUERY_CW = 16;

// One ray/rectangle query as it sits on the input port.
typedef struct {
	logic signed [QUERY_CW-1:0] ox;
	logic signed [QUERY_CW-1:0] oy;
	logic signed [QUERY_CW-1:0] vx;
	logic signed [QUERY_CW-1:0] vy;
	logic signed [QUERY_CW-1:0] cx;
	logic signed [QUERY_CW-1:0] cy;
	logic        [QUERY_CW-2:0] w;
	logic        [QUERY_CW-2:0] h;
} hit_query_t;

// Expected hit flag and per-edge mask for one query.
typedef struct {
	logic                            hit;
	logic [srht_pkg::NUM_EDGES-1:0] edge_hits;
} hit_verdict_t;

// Hit predictor plus the queue of verdicts still owed by the block.
class hit_scoreboard;
	hit_verdict_t pending_verdicts[$];
	int           mismatches;

	function new();
		mismatches = 0;
	endfunction

	// Sign of ax*by - ay*bx; 64-bit is far wider than any product here.
	function int cross_sign(input longint ax, input longint ay, input longint bx,
		input longint by);
		longint d;
		d = ax * by - ay * bx;
		return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
	endfunction

	// Two-sided straddle test: reject only on a strictly positive sign product.
	function bit segments_meet(input longint a1x, input longint a1y, input longint a2x,
		input longint a2y, input longint b1x, input longint b1y, input longint b2x,
		input longint b2y);
		if (cross_sign(b2x - b1x, b2y - b1y, a1x - b1x, a1y - b1y) *
			cross_sign(b2x - b1x, b2y - b1y, a2x - b1x, a2y - b1y) > 0)
			return 1'b0;
		if (cross_sign(a2x - a1x, a2y - a1y, b1x - a1x, b1y - a1y) *
			cross_sign(a2x - a1x, a2y - a1y, b2x - a1x, b2y - a1y) > 0)
			return 1'b0;
		return 1'b1;
	endfunction

	function void note_query(input hit_query_t q);
		longint       ox, oy, ex, ey;
		longint       kx[srht_pkg::NUM_EDGES];
		longint       ky[srht_pkg::NUM_EDGES];
		hit_verdict_t v;
		ox = longint'(q.ox);
		oy = longint'(q.oy);
		ex = ox + longint'(q.vx);
		ey = oy + longint'(q.vy);
		// corners walk top, right, bottom, left
		kx[srht_pkg::EDGE_TOP]    = longint'(q.cx);
		ky[srht_pkg::EDGE_TOP]    = longint'(q.cy);
		kx[srht_pkg::EDGE_RIGHT]  = longint'(q.cx) + longint'(q.w);
		ky[srht_pkg::EDGE_RIGHT]  = longint'(q.cy);
		kx[srht_pkg::EDGE_BOTTOM] = kx[srht_pkg::EDGE_RIGHT];
		ky[srht_pkg::EDGE_BOTTOM] = longint'(q.cy) + longint'(q.h);
		kx[srht_pkg::EDGE_LEFT]   = longint'(q.cx);
		ky[srht_pkg::EDGE_LEFT]   = ky[srht_pkg::EDGE_BOTTOM];
		v.edge_hits = '0;
		for (int k = 0; k < srht_pkg::NUM_EDGES; k++)
			v.edge_hits[k] = segments_meet(ox, oy, ex, ey, kx[k], ky[k],
				kx[(k + 1) % srht_pkg::NUM_EDGES], ky[(k + 1) % srht_pkg::NUM_EDGES]);
		v.hit = |v.edge_hits;
		pending_verdicts.push_back(v);
	endfunction

	function void check_result(input logic hit, input logic [srht_pkg::NUM_EDGES-1:0] edge_hits);
		hit_verdict_t v;
		if (pending_verdicts.size() == 0) begin
			if (mismatches < 10)
				$display("mismatch: result hit=%b edge_hits=%b with nothing pending",
					hit, edge_hits);
			mismatches++;
			return;
		end
		v = pending_verdicts.pop_front();
		if (hit !== v.hit || edge_hits !== v.edge_hits) begin
			if (mismatches < 10)
				$display("mismatch at %0t: hit exp %b got %b, edge_hits exp %b got %b",
					$realtime, v.hit, hit, v.edge_hits, edge_hits);
			mismatches++;
		end
	endfunction
endclass

module segment_rectangle_hit_test_core_test;
	import srht_pkg::*;

	localparam int CW            = QUERY_CW;
	localparam int RANDOM_COUNT  = 1250;
	localparam int CALM_TAIL     = 150;    // last transfers run without idling
	localparam int PRESSURE_AT   = 400;    // transfers sent before the long hold-off
	localparam int PRESSURE_LEN  = 100;    // cycles of the long hold-off
	localparam int DRAIN_CYCLES  = 16;     // extra wait past the last result
	localparam int CYCLE_LIMIT   = 100000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [CW-1:0] ray_origin_x;
	logic signed [CW-1:0] ray_origin_y;
	logic signed [CW-1:0] ray_vector_x;
	logic signed [CW-1:0] ray_vector_y;
	logic signed [CW-1:0] rect_corner_x;
	logic signed [CW-1:0] rect_corner_y;
	logic        [CW-2:0] rect_width;
	logic        [CW-2:0] rect_height;
	logic                 out_valid;
	logic                 out_stall;
	logic                 hit;
	logic [NUM_EDGES-1:0] edge_hits;

	hit_scoreboard sb;
	int            queries_sent;
	int            total_queries;
	bit            calm;
	int            cycle_count;

	segment_rectangle_hit_test_core #(
		.COORD_WIDTH(CW)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ray_origin_x(ray_origin_x),
		.ray_origin_y(ray_origin_y),
		.ray_vector_x(ray_vector_x),
		.ray_vector_y(ray_vector_y),
		.rect_corner_x(rect_corner_x),
		.rect_corner_y(rect_corner_y),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.edge_hits(edge_hits)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Quiet the idle bursts once the tail of the run is reached.
	assign calm = (total_queries > 0) && (queries_sent >= total_queries - CALM_TAIL);

	function automatic hit_query_t make_query(input int ox, input int oy, input int vx,
		input int vy, input int cx, input int cy, input int w, input int h);
		hit_query_t q;
		q.ox = CW'(ox);
		q.oy = CW'(oy);
		q.vx = CW'(vx);
		q.vy = CW'(vy);
		q.cx = CW'(cx);
		q.cy = CW'(cy);
		q.w  = (CW-1)'(w);
		q.h  = (CW-1)'(h);
		return q;
	endfunction

	// Value within +/- span of center.
	function automatic int near(input int center, input int span);
		return center + int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// One of the corner values of a signed coordinate.
	function automatic int extreme_coord();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	// Random query: in four of ten cases rays thrown around a small nearby box, so that
	// crossings, touches and near misses all come up; the rest is raw noise,
	// degenerate boxes and rays, rays lying on an edge line, and extremes.
	function automatic hit_query_t random_query();
		hit_query_t q;
		int         kind, bx, by, bw, bh, ox, oy, vx, vy;
		kind = $urandom_range(0, 9);
		bx = int'($urandom_range(0, 40000)) - 20000;
		by = int'($urandom_range(0, 40000)) - 20000;
		bw = $urandom_range(0, 800);
		bh = $urandom_range(0, 800);
		ox = near(bx + bw / 2, 1200);
		oy = near(by + bh / 2, 1200);
		vx = near(0, 1500);
		vy = near(0, 1500);
		case (kind)
			0, 1, 2: begin
				q.ox = CW'($urandom);
				q.oy = CW'($urandom);
				q.vx = CW'($urandom);
				q.vy = CW'($urandom);
				q.cx = CW'($urandom);
				q.cy = CW'($urandom);
				q.w  = (CW-1)'($urandom);
				q.h  = (CW-1)'($urandom);
				return q;
			end
			7: begin
				// degenerate box and/or point ray
				case ($urandom_range(0, 3))
					0: bw = 0;
					1: bh = 0;
					2: begin
						bw = 0;
						bh = 0;
					end
					default: ;
				endcase
				if ($urandom_range(0, 1) == 1) begin
					vx = 0;
					vy = 0;
					if ($urandom_range(0, 1) == 1)
						ox = bx + int'($urandom_range(0, bw));
					if ($urandom_range(0, 1) == 1)
						oy = by;
				end
			end
			8: begin
				// ray lying on the line of an edge, overlapping or disjoint
				if ($urandom_range(0, 1) == 1) begin
					oy = ($urandom_range(0, 1) == 1) ? by : by + bh;
					vy = 0;
				end else begin
					ox = ($urandom_range(0, 1) == 1) ? bx : bx + bw;
					vx = 0;
				end
			end
			9: return make_query(extreme_coord(), extreme_coord(), extreme_coord(),
				extreme_coord(), extreme_coord(), extreme_coord(),
				($urandom_range(0, 2) == 0) ? 0 : 32767 * int'($urandom_range(0, 1)),
				($urandom_range(0, 2) == 0) ? 0 : 32767 * int'($urandom_range(0, 1)));
			default: ;
		endcase
		return make_query(ox, oy, vx, vy, bx, by, bw, bh);
	endfunction

	// Present one query at the falling edge and hold it until the transfer.
	task automatic send_query(input hit_query_t q);
		@(negedge clk);
		ray_origin_x  = q.ox;
		ray_origin_y  = q.oy;
		ray_vector_x  = q.vx;
		ray_vector_y  = q.vy;
		rect_corner_x = q.cx;
		rect_corner_y = q.cy;
		rect_width    = q.w;
		rect_height   = q.h;
		in_valid      = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_query(q);
		queries_sent++;
	endtask

	// Drop valid for a short random burst, unless the tail is reached.
	task automatic maybe_idle_input();
		int gap;
		if (calm || $urandom_range(0, 5) != 0)
			return;
		gap = $urandom_range(1, 4);
		@(negedge clk);
		in_valid = 1'b0;
		repeat (gap - 1) @(negedge clk);
	endtask

	// Main stimulus: reset, directed corner cases, random stream, drain.
	initial begin
		hit_query_t directed[$];
		sb            = new();
		queries_sent  = 0;
		total_queries = 0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		ray_origin_x  = '0;
		ray_origin_y  = '0;
		ray_vector_x  = '0;
		ray_vector_y  = '0;
		rect_corner_x = '0;
		rect_corner_y = '0;
		rect_width    = '0;
		rect_height   = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// all zero: point ray on a point box
		directed.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0));
		// field extremes
		directed.push_back(make_query(-32768, -32768, 32767, 32767, -32768, -32768, 32767,
			32767));
		directed.push_back(make_query(32767, 32767, -32768, -32768, 32767, 32767, 32767,
			32767));
		directed.push_back(make_query(0, 0, -32768, 32767, -1000, -1000, 2000, 2000));
		directed.push_back(make_query(-32768, 32767, 0, -32768, -32768, -32768, 32767, 32767));
		directed.push_back(make_query(-1, -1, 1, 1, 32767, -32768, 0, 32767));
		// straight through left and right edges
		directed.push_back(make_query(-100, 50, 300, 0, 0, 0, 100, 100));
		// straight through top and bottom edges
		directed.push_back(make_query(50, -200, 0, 500, 0, 0, 100, 100));
		// wholly inside, wholly outside
		directed.push_back(make_query(20, 20, 10, 10, 0, 0, 100, 100));
		directed.push_back(make_query(200, 200, 50, -10, 0, 0, 100, 100));
		// point ray on an edge, and just off it
		directed.push_back(make_query(50, 0, 0, 0, 0, 0, 100, 100));
		directed.push_back(make_query(50, 10, 0, 0, 0, 0, 100, 100));
		// zero width, zero height, both zero
		directed.push_back(make_query(-50, 50, 100, 0, 0, 0, 0, 100));
		directed.push_back(make_query(50, -50, 0, 100, 0, 0, 100, 0));
		directed.push_back(make_query(0, 0, 20, 20, 10, 10, 0, 0));
		// collinear with the top edge but disjoint
		directed.push_back(make_query(200, 0, 100, 0, 0, 0, 100, 100));
		// ray ending on a corner, ray ending on an edge
		directed.push_back(make_query(-50, -50, 50, 50, 0, 0, 100, 100));
		directed.push_back(make_query(150, 50, -50, 0, 0, 0, 100, 100));
		// diagonal through two opposite corners
		directed.push_back(make_query(-10, -10, 120, 120, 0, 0, 100, 100));

		total_queries = directed.size() + RANDOM_COUNT;
		foreach (directed[i]) begin
			maybe_idle_input();
			send_query(directed[i]);
		end
		repeat (RANDOM_COUNT) begin
			maybe_idle_input();
			send_query(random_query());
		end
		@(negedge clk);
		in_valid = 1'b0;

		// Wait for every verdict, then a little longer to catch strays.
		while (sb.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Receiver back-pressure: short random bursts, one long hold-off so the
	// pipe fills and stalls its input, and none in the tail.
	initial begin
		bit pressure_done;
		int burst;
		pressure_done = 1'b0;
		out_stall     = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!pressure_done && queries_sent >= PRESSURE_AT) begin
				out_stall = 1'b1;
				for (int held = 1; held < PRESSURE_LEN; held++)
					@(negedge clk);
				pressure_done = 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				burst     = $urandom_range(1, 4);
				out_stall = 1'b1;
				repeat (burst - 1) @(negedge clk);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// Check each result transfer against the oldest pending verdict.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(hit, edge_hits);
	end

	// Watchdog: end the run if it hangs.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

endmodule
